[sv/pnag_pkg.sv]
// Package for the pyramid neighborhood address generator.
// Holds field widths, neighborhood offsets and the coordinate helper functions.
// No dependencies.
package pnag_pkg;

  localparam int MAX_DEPTH_LEVELS = 4;
  localparam int COORD_BITS       = 12;
  localparam int PIXEL_CHANNELS   = 3;
  localparam int LEVEL_BITS       = 2;
  localparam int COUNT_BITS       = 3;
  localparam int DIM_BITS         = COORD_BITS + 1;
  localparam int WRAP_BITS        = DIM_BITS + 2;
  localparam int PROD_BITS        = 2 * COORD_BITS;
  localparam int ADDR_BITS        = 26;
  localparam int SAME_COUNT       = 12;
  localparam int PARENT_COUNT     = 9;
  localparam int TOTAL_COUNT      = SAME_COUNT + PARENT_COUNT;
  localparam int IDX_BITS         = 5;
  localparam int CFG_IDX_BITS     = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_BASE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BASE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL_COUNT = 2'd2;

  localparam logic [DIM_BITS-1:0] DIM_TOP = DIM_BITS'(1 << COORD_BITS);

  function automatic logic [DIM_BITS-1:0] clamp_base(logic [DIM_BITS-1:0] v);
    logic [DIM_BITS-1:0] r;
    r = v;
    if (v == '0) r = DIM_BITS'(1);
    else if (v > DIM_TOP) r = DIM_TOP;
    return r;
  endfunction

  function automatic logic [DIM_BITS-1:0] level_dim(logic [DIM_BITS-1:0] base,
                                                    logic [COUNT_BITS-1:0] lvl);
    logic [DIM_BITS-1:0] d;
    d = clamp_base(base) >> lvl;
    if (d == '0) d = DIM_BITS'(1);
    return d;
  endfunction

  function automatic logic [COUNT_BITS-1:0] eff_count(logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS-1:0] r;
    r = v;
    if (v == '0) r = COUNT_BITS'(1);
    else if (v > COUNT_BITS'(MAX_DEPTH_LEVELS)) r = COUNT_BITS'(MAX_DEPTH_LEVELS);
    return r;
  endfunction

  function automatic logic signed [2:0] row_offset(logic [IDX_BITS-1:0] idx);
    logic signed [2:0] r;
    unique case (idx)
      5'd0, 5'd1, 5'd2, 5'd3, 5'd4:      r = -3'sd2;
      5'd5, 5'd6, 5'd7, 5'd8, 5'd9:      r = -3'sd1;
      5'd10, 5'd11:                      r = 3'sd0;
      5'd12, 5'd13, 5'd14:               r = -3'sd1;
      5'd15, 5'd16, 5'd17:               r = 3'sd0;
      5'd18, 5'd19, 5'd20:               r = 3'sd1;
      default:                           r = 3'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [2:0] col_offset(logic [IDX_BITS-1:0] idx);
    logic signed [2:0] r;
    unique case (idx)
      5'd0, 5'd5, 5'd10:                 r = -3'sd2;
      5'd1, 5'd6, 5'd11:                 r = -3'sd1;
      5'd2, 5'd7:                        r = 3'sd0;
      5'd3, 5'd8:                        r = 3'sd1;
      5'd4, 5'd9:                        r = 3'sd2;
      5'd12, 5'd15, 5'd18:               r = -3'sd1;
      5'd13, 5'd16, 5'd19:               r = 3'sd0;
      5'd14, 5'd17, 5'd20:               r = 3'sd1;
      default:                           r = 3'sd0;
    endcase
    return r;
  endfunction

  // The sum may lie up to two sizes outside the range, so two corrections per side.
  function automatic logic [COORD_BITS-1:0] wrap_coord(logic [DIM_BITS-1:0] c,
                                                       logic signed [2:0] off,
                                                       logic [DIM_BITS-1:0] size);
    logic signed [WRAP_BITS-1:0] t;
    logic signed [WRAP_BITS-1:0] s;
    s = signed'(WRAP_BITS'(size));
    t = signed'(WRAP_BITS'(c)) + WRAP_BITS'(off);
    if (t < 0) t = t + s;
    if (t < 0) t = t + s;
    if (t >= s) t = t - s;
    if (t >= s) t = t - s;
    return t[COORD_BITS-1:0];
  endfunction

endpackage

[sv/pyramid_neighborhood_address_gen_top.sv]
// Top level of the pyramid neighborhood address generator.
// Uses pnag_pkg for widths, offsets and coordinate helpers.
//
// A request on the in_ channel carries a pyramid level and a pixel coordinate.
// The block answers with the word addresses of the causal neighborhood on the
// out_ channel: 12 addresses at the same level, then 9 addresses at the parent
// level when the level is not the top one, with out_last on the final address.
// A request outside the configured pyramid gives one result with
// out_bad_request set.
// One request is worked on at a time and in_ready is high only while idle.
// A single shared unit wraps a coordinate pair into row_r and col_r and
// forms the row-major index with one multiplier in the next cycle, into
// prod_r. After acceptance a request passes the check, wrap, multiply and
// emit states, and each further address passes multiply and emit again.
// A new request is accepted only after the last address has been loaded
// into the output register, or for a bad request after its single result.
// Results leave through an output register; when the receiver stalls the
// sequencer waits with the next address and a new request may be accepted
// while the final result still waits to be taken.
// Reset empties the output register, returns to idle and sets the registers to
// a 64 by 64 base level with 4 levels. Configuration writes take effect at once.
module pyramid_neighborhood_address_gen_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [pnag_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [pnag_pkg::DIM_BITS-1:0]        cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [pnag_pkg::LEVEL_BITS-1:0]      in_level,
  input  logic [pnag_pkg::COORD_BITS-1:0]      in_pos_x,
  input  logic [pnag_pkg::COORD_BITS-1:0]      in_pos_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [pnag_pkg::LEVEL_BITS-1:0]      out_source_level,
  output logic                                 out_from_parent,
  output logic [pnag_pkg::ADDR_BITS-1:0]       out_word_address,
  output logic                                 out_bad_request,
  output logic                                 out_last
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_WRAP  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_BAD   = 3'd5;

  localparam logic [pnag_pkg::IDX_BITS-1:0] IDX_SAME_LAST =
    pnag_pkg::IDX_BITS'(pnag_pkg::SAME_COUNT - 1);
  localparam logic [pnag_pkg::IDX_BITS-1:0] IDX_ALL_LAST =
    pnag_pkg::IDX_BITS'(pnag_pkg::TOTAL_COUNT - 1);
  localparam logic [pnag_pkg::IDX_BITS-1:0] IDX_PARENT_FIRST =
    pnag_pkg::IDX_BITS'(pnag_pkg::SAME_COUNT);

  logic [2:0]                          state_r, state_nxt;
  logic [pnag_pkg::DIM_BITS-1:0]       base_width_r, base_height_r;
  logic [pnag_pkg::COUNT_BITS-1:0]     level_count_r;
  logic                                out_valid_r, out_valid_nxt;
  logic [pnag_pkg::IDX_BITS-1:0]       idx_r, idx_nxt;
  logic                                has_parent_r;

  logic [pnag_pkg::LEVEL_BITS-1:0]     lvl_r;
  logic [pnag_pkg::COORD_BITS-1:0]     px_r, py_r;
  logic [pnag_pkg::DIM_BITS-1:0]       w_r, h_r, pw_r, ph_r;
  logic [pnag_pkg::COORD_BITS-1:0]     row_r, col_r;
  logic [pnag_pkg::PROD_BITS-1:0]      prod_r;
  logic [pnag_pkg::LEVEL_BITS-1:0]     out_level_r;
  logic                                out_parent_r;
  logic [pnag_pkg::ADDR_BITS-1:0]      out_addr_r;
  logic                                out_bad_r;
  logic                                out_last_r;

  logic [pnag_pkg::COUNT_BITS-1:0]     count;
  logic [pnag_pkg::COUNT_BITS-1:0]     lvl_ext;
  logic [pnag_pkg::DIM_BITS-1:0]       w_chk, h_chk, pw_chk, ph_chk;
  logic                                bad_chk, parent_chk;
  logic [pnag_pkg::IDX_BITS-1:0]       wrap_idx;
  logic                                wrap_par;
  logic [pnag_pkg::DIM_BITS-1:0]       wrap_cx, wrap_cy, wrap_w, wrap_h;
  logic [pnag_pkg::COORD_BITS-1:0]     row_calc, col_calc;
  logic                                mul_par;
  logic [pnag_pkg::DIM_BITS-1:0]       mul_w;
  logic [pnag_pkg::PROD_BITS-1:0]      prod_calc;
  logic                                slot_free, emit_last, load_out;

  assign count      = pnag_pkg::eff_count(level_count_r);
  assign lvl_ext    = pnag_pkg::COUNT_BITS'(lvl_r);
  assign w_chk      = pnag_pkg::level_dim(base_width_r, lvl_ext);
  assign h_chk      = pnag_pkg::level_dim(base_height_r, lvl_ext);
  assign pw_chk     = pnag_pkg::level_dim(base_width_r, lvl_ext + 3'd1);
  assign ph_chk     = pnag_pkg::level_dim(base_height_r, lvl_ext + 3'd1);
  assign bad_chk    = (lvl_ext >= count) ||
                      (pnag_pkg::DIM_BITS'(px_r) >= w_chk) ||
                      (pnag_pkg::DIM_BITS'(py_r) >= h_chk);
  assign parent_chk = (lvl_ext + 3'd1) < count;

  assign wrap_idx = (state_r == S_EMIT) ? idx_r + 5'd1 : idx_r;
  assign wrap_par = wrap_idx >= IDX_PARENT_FIRST;
  assign wrap_cx  = wrap_par ? pnag_pkg::DIM_BITS'(px_r >> 1) : pnag_pkg::DIM_BITS'(px_r);
  assign wrap_cy  = wrap_par ? pnag_pkg::DIM_BITS'(py_r >> 1) : pnag_pkg::DIM_BITS'(py_r);
  assign wrap_w   = wrap_par ? pw_r : w_r;
  assign wrap_h   = wrap_par ? ph_r : h_r;
  assign row_calc = pnag_pkg::wrap_coord(wrap_cy, pnag_pkg::row_offset(wrap_idx), wrap_h);
  assign col_calc = pnag_pkg::wrap_coord(wrap_cx, pnag_pkg::col_offset(wrap_idx), wrap_w);

  assign mul_par   = idx_r >= IDX_PARENT_FIRST;
  assign mul_w     = mul_par ? pw_r : w_r;
  assign prod_calc = pnag_pkg::PROD_BITS'(row_r * mul_w) + pnag_pkg::PROD_BITS'(col_r);

  assign slot_free = !out_valid_r || out_ready;
  assign emit_last = has_parent_r ? (idx_r == IDX_ALL_LAST) : (idx_r == IDX_SAME_LAST);
  assign load_out  = slot_free && ((state_r == S_EMIT) || (state_r == S_BAD));

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        idx_nxt   = '0;
        state_nxt = bad_chk ? S_BAD : S_WRAP;
      end
      S_WRAP: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          if (emit_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + 5'd1;
            state_nxt = S_MUL;
          end
        end
      end
      S_BAD: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      idx_r         <= '0;
      has_parent_r  <= 1'b0;
      base_width_r  <= pnag_pkg::DIM_BITS'(64);
      base_height_r <= pnag_pkg::DIM_BITS'(64);
      level_count_r <= pnag_pkg::COUNT_BITS'(4);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      if (state_r == S_CHECK) has_parent_r <= parent_chk;
      if (cfg_we) begin
        unique case (cfg_index)
          pnag_pkg::REG_BASE_WIDTH:  base_width_r  <= cfg_wdata;
          pnag_pkg::REG_BASE_HEIGHT: base_height_r <= cfg_wdata;
          pnag_pkg::REG_LEVEL_COUNT: level_count_r <= cfg_wdata[pnag_pkg::COUNT_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      lvl_r <= in_level;
      px_r  <= in_pos_x;
      py_r  <= in_pos_y;
    end
    if (state_r == S_CHECK) begin
      w_r  <= w_chk;
      h_r  <= h_chk;
      pw_r <= pw_chk;
      ph_r <= ph_chk;
    end
    if ((state_r == S_WRAP) || ((state_r == S_EMIT) && slot_free)) begin
      row_r <= row_calc;
      col_r <= col_calc;
    end
    if (state_r == S_MUL) prod_r <= prod_calc;
    if (load_out) begin
      if (state_r == S_BAD) begin
        out_level_r  <= lvl_r;
        out_parent_r <= 1'b0;
        out_addr_r   <= '0;
        out_bad_r    <= 1'b1;
        out_last_r   <= 1'b1;
      end else begin
        out_level_r  <= mul_par ? lvl_r + 2'd1 : lvl_r;
        out_parent_r <= mul_par;
        out_addr_r   <= pnag_pkg::ADDR_BITS'(prod_r) *
                        pnag_pkg::ADDR_BITS'(pnag_pkg::PIXEL_CHANNELS);
        out_bad_r    <= 1'b0;
        out_last_r   <= emit_last;
      end
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_source_level = out_level_r;
  assign out_from_parent  = out_parent_r;
  assign out_word_address = out_addr_r;
  assign out_bad_request  = out_bad_r;
  assign out_last         = out_last_r;

endmodule

[verif/pyramid_neighborhood_address_gen_top_test.sv]
// Self-checking testbench for pyramid_neighborhood_address_gen_top.
// Predicts the neighborhood addresses of each request and checks every result in order.
// Depends on pnag_pkg and the top level RTL only.
module pyramid_neighborhood_address_gen_top_test;

  localparam int MAX_DEPTH_LEVELS = pnag_pkg::MAX_DEPTH_LEVELS;
  localparam int COORD_BITS       = pnag_pkg::COORD_BITS;
  localparam int PIXEL_CHANNELS   = pnag_pkg::PIXEL_CHANNELS;
  localparam int LEVEL_BITS       = pnag_pkg::LEVEL_BITS;
  localparam int COUNT_BITS       = pnag_pkg::COUNT_BITS;
  localparam int DIM_BITS         = pnag_pkg::DIM_BITS;
  localparam int ADDR_BITS        = pnag_pkg::ADDR_BITS;
  localparam int SAME_COUNT       = pnag_pkg::SAME_COUNT;
  localparam int PARENT_COUNT     = pnag_pkg::PARENT_COUNT;
  localparam int CFG_IDX_BITS     = pnag_pkg::CFG_IDX_BITS;
  localparam logic [CFG_IDX_BITS-1:0] REG_BASE_WIDTH  = pnag_pkg::REG_BASE_WIDTH;
  localparam logic [CFG_IDX_BITS-1:0] REG_BASE_HEIGHT = pnag_pkg::REG_BASE_HEIGHT;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL_COUNT = pnag_pkg::REG_LEVEL_COUNT;

  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] source_level;
    logic                  from_parent;
    logic [ADDR_BITS-1:0]  word_address;
    logic                  bad_request;
    logic                  last;
  } addr_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [DIM_BITS-1:0]     cfg_wdata;
  logic                    in_valid;
  logic                    in_ready;
  logic [LEVEL_BITS-1:0]   in_level;
  logic [COORD_BITS-1:0]   in_pos_x;
  logic [COORD_BITS-1:0]   in_pos_y;
  logic                    out_valid;
  logic                    out_ready;
  logic [LEVEL_BITS-1:0]   out_source_level;
  logic                    out_from_parent;
  logic [ADDR_BITS-1:0]    out_word_address;
  logic                    out_bad_request;
  logic                    out_last;

  logic [DIM_BITS-1:0]     geom_base_width;
  logic [DIM_BITS-1:0]     geom_base_height;
  logic [COUNT_BITS-1:0]   geom_level_count;

  addr_result_t pending_addresses[$];
  int send_idle_pct;
  int recv_idle_pct;
  int error_count;
  int request_count;
  int rejected_count;
  int parent_window_count;
  int address_count;
  int write_count;
  int cycle_count;

  pyramid_neighborhood_address_gen_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_level         (in_level),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_source_level (out_source_level),
    .out_from_parent  (out_from_parent),
    .out_word_address (out_word_address),
    .out_bad_request  (out_bad_request),
    .out_last         (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned level_size(logic [DIM_BITS-1:0] base, int unsigned lvl);
    int unsigned b;
    b = base;
    if (b == 0) b = 1;
    else if (b > (1 << COORD_BITS)) b = 1 << COORD_BITS;
    b = b >> lvl;
    if (b == 0) b = 1;
    return b;
  endfunction

  function automatic int unsigned active_levels();
    int unsigned n;
    n = geom_level_count;
    if (n == 0) n = 1;
    else if (n > MAX_DEPTH_LEVELS) n = MAX_DEPTH_LEVELS;
    return n;
  endfunction

  function automatic int unsigned wrap_to(int unsigned c, int off, int unsigned size);
    int t;
    t = int'(c) + 2 * int'(size) + off;
    return t % size;
  endfunction

  function automatic logic [ADDR_BITS-1:0] pixel_word(int unsigned row, int unsigned col,
                                                      int unsigned width);
    longint a;
    a = (longint'(row) * width + col) * PIXEL_CHANNELS;
    return a[ADDR_BITS-1:0];
  endfunction

  function automatic void predict_neighborhood(logic [LEVEL_BITS-1:0] lvl,
                                               logic [COORD_BITS-1:0] x,
                                               logic [COORD_BITS-1:0] y);
    addr_result_t r;
    int unsigned levels, w, h, pw, ph, cx, cy;
    int dr, dc;
    bit has_parent;
    levels = active_levels();
    w = level_size(geom_base_width, lvl);
    h = level_size(geom_base_height, lvl);
    if (lvl >= levels || x >= w || y >= h) begin
      r = '{source_level: lvl, from_parent: 1'b0, word_address: '0,
            bad_request: 1'b1, last: 1'b1};
      pending_addresses.push_back(r);
      rejected_count++;
      return;
    end
    has_parent = (lvl + 1 < levels);
    for (int i = 0; i < SAME_COUNT; i++) begin
      dr = (i < 5) ? -2 : (i < 10) ? -1 : 0;
      dc = (i < 10) ? (i % 5) - 2 : i - 12;
      r.source_level = lvl;
      r.from_parent  = 1'b0;
      r.word_address = pixel_word(wrap_to(y, dr, h), wrap_to(x, dc, w), w);
      r.bad_request  = 1'b0;
      r.last         = (i == SAME_COUNT - 1) && !has_parent;
      pending_addresses.push_back(r);
    end
    if (has_parent) begin
      parent_window_count++;
      pw = level_size(geom_base_width, lvl + 1);
      ph = level_size(geom_base_height, lvl + 1);
      cx = x >> 1;
      cy = y >> 1;
      for (int i = 0; i < PARENT_COUNT; i++) begin
        r.source_level = LEVEL_BITS'(lvl + 1);
        r.from_parent  = 1'b1;
        r.word_address = pixel_word(wrap_to(cy, i / 3 - 1, ph), wrap_to(cx, i % 3 - 1, pw), pw);
        r.bad_request  = 1'b0;
        r.last         = (i == PARENT_COUNT - 1);
        pending_addresses.push_back(r);
      end
    end
  endfunction

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    addr_result_t seen;
    addr_result_t want;
    seen = {out_source_level, out_from_parent, out_word_address, out_bad_request, out_last};
    if (rst_n && out_valid && out_ready) begin
      address_count++;
      if (pending_addresses.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display({"unexpected result with nothing pending: ",
                    "level %0d parent %0b addr %0d bad %0b last %0b"},
                   seen.source_level, seen.from_parent, seen.word_address,
                   seen.bad_request, seen.last);
      end else begin
        want = pending_addresses.pop_front();
        if (seen !== want) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display({"result %0d differs: ",
                      "expected level %0d parent %0b addr %0d bad %0b last %0b, ",
                      "got level %0d parent %0b addr %0d bad %0b last %0b"},
                     address_count, want.source_level, want.from_parent, want.word_address,
                     want.bad_request, want.last, seen.source_level, seen.from_parent,
                     seen.word_address, seen.bad_request, seen.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("pyramid_neighborhood_address_gen_top: mismatch");
      $finish;
    end
  end

  task automatic send_request(input logic [LEVEL_BITS-1:0] lvl, input logic [COORD_BITS-1:0] x,
                              input logic [COORD_BITS-1:0] y);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid = 1'b1;
    in_level = lvl;
    in_pos_x = x;
    in_pos_y = y;
    do @(posedge clk); while (!in_ready);
    predict_neighborhood(lvl, x, y);
    request_count++;
    @(negedge clk);
  endtask

  task automatic wait_for_idle();
    in_valid = 1'b0;
    while (pending_addresses.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                input logic [DIM_BITS-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    write_count++;
    case (idx)
      REG_BASE_WIDTH:  geom_base_width = value;
      REG_BASE_HEIGHT: geom_base_height = value;
      REG_LEVEL_COUNT: geom_level_count = value[COUNT_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input logic [DIM_BITS-1:0] w, input logic [DIM_BITS-1:0] h,
                              input logic [DIM_BITS-1:0] levels);
    wait_for_idle();
    write_register(REG_BASE_WIDTH, w);
    write_register(REG_BASE_HEIGHT, h);
    write_register(REG_LEVEL_COUNT, levels);
  endtask

  function automatic logic [DIM_BITS-1:0] pick_base_size();
    case ($urandom_range(9))
      0:       return '0;
      1:       return DIM_BITS'(1 << COORD_BITS);
      2:       return DIM_BITS'($urandom_range((1 << DIM_BITS) - 1, (1 << COORD_BITS) + 1));
      3, 4, 5,
      6:       return DIM_BITS'($urandom_range(16, 1));
      default: return DIM_BITS'($urandom_range(1 << COORD_BITS, 1));
    endcase
  endfunction

  task automatic test_default_geometry();
    send_request(2'd0, 12'd0, 12'd0);
    send_request(2'd0, 12'd63, 12'd63);
    send_request(2'd0, 12'd17, 12'd40);
    send_request(2'd1, 12'd31, 12'd0);
    send_request(2'd3, 12'd7, 12'd7);
  endtask

  task automatic test_bad_requests();
    set_geometry(13'd64, 13'd64, 13'd2);
    send_request(2'd2, 12'd0, 12'd0);
    send_request(2'd3, 12'd4095, 12'd4095);
    send_request(2'd0, 12'd64, 12'd0);
    send_request(2'd0, 12'd0, 12'd64);
    send_request(2'd1, 12'd4095, 12'd0);
  endtask

  // Odd sizes put the halved coordinate outside the parent level, and tiny
  // sizes make offsets wrap more than once or levels shrink to one pixel.
  task automatic test_odd_sizes();
    set_geometry(13'd5, 13'd7, 13'd4);
    send_request(2'd0, 12'd4, 12'd6);
    send_request(2'd1, 12'd1, 12'd2);
    send_request(2'd2, 12'd0, 12'd0);
    send_request(2'd3, 12'd0, 12'd0);
    set_geometry(13'd1, 13'd2, 13'd3);
    send_request(2'd0, 12'd0, 12'd1);
    send_request(2'd1, 12'd0, 12'd0);
  endtask

  task automatic test_register_extremes();
    set_geometry(13'd0, 13'd8191, 13'd0);
    write_register(REG_UNUSED, 13'd1);
    send_request(2'd0, 12'd0, 12'd4095);
    send_request(2'd0, 12'd0, 12'd0);
    send_request(2'd0, 12'd1, 12'd0);
    set_geometry(13'd4096, 13'd4096, 13'd7);
    send_request(2'd0, 12'd4095, 12'd4095);
    send_request(2'd3, 12'd511, 12'd511);
    send_request(2'd0, 12'd2048, 12'd1);
  endtask

  task automatic test_random_requests(input int n, input int s_pct, input int r_pct);
    logic [LEVEL_BITS-1:0] lvl;
    logic [COORD_BITS-1:0] x, y;
    int unsigned levels;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0)
        set_geometry(pick_base_size(), pick_base_size(), DIM_BITS'($urandom_range(7)));
      levels = active_levels();
      lvl = LEVEL_BITS'(($urandom_range(9) < 8) ? $urandom_range(levels - 1)
                                                : $urandom_range(3));
      if ($urandom_range(99) < 85) begin
        x = COORD_BITS'($urandom_range(level_size(geom_base_width, lvl) - 1));
        y = COORD_BITS'($urandom_range(level_size(geom_base_height, lvl) - 1));
      end else begin
        x = COORD_BITS'($urandom_range((1 << COORD_BITS) - 1));
        y = COORD_BITS'($urandom_range((1 << COORD_BITS) - 1));
      end
      send_request(lvl, x, y);
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_level = '0;
    in_pos_x = '0;
    in_pos_y = '0;
    out_ready = 1'b0;
    geom_base_width = 13'd64;
    geom_base_height = 13'd64;
    geom_level_count = 3'd4;
    send_idle_pct = 18;
    recv_idle_pct = 67;
    error_count = 0;
    request_count = 0;
    rejected_count = 0;
    parent_window_count = 0;
    address_count = 0;
    write_count = 0;
    cycle_count = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_default_geometry();
    test_bad_requests();
    test_odd_sizes();
    test_register_extremes();
    test_random_requests(90, 18, 67);
    test_random_requests(80, 67, 18);
    test_random_requests(80, 0, 0);

    wait_for_idle();
    repeat (50) @(negedge clk);
    $display("Covered %0d requests (%0d rejected, %0d with a parent window)",
             request_count, rejected_count, parent_window_count);
    $display("and %0d register writes; checked %0d addresses in %0d cycles, %0d errors.",
             write_count, address_count, cycle_count, error_count);
    if (error_count == 0 && pending_addresses.size() == 0) begin
      $display("pyramid_neighborhood_address_gen_top: match");
    end else begin
      $display("pyramid_neighborhood_address_gen_top: mismatch");
    end
    $finish;
  end

endmodule

[pyramid_neighborhood_address_gen_top.f]
sv/pnag_pkg.sv
sv/pyramid_neighborhood_address_gen_top.sv
verif/pyramid_neighborhood_address_gen_top_test.sv
